>>> hdl/srps_pkg.sv
// shared types and constants for the sparse random projection signature block
package srps_pkg;

   localparam int NUM_PROJECTIONS = 32;
   localparam int PROJ_IDX_WIDTH  = $clog2(NUM_PROJECTIONS);
   localparam int COUNT_WIDTH     = 6;
   localparam int SIG_WIDTH       = 32;
   localparam int WORD_WIDTH      = 32;
   localparam int VALUE_WIDTH     = 16;
   localparam int PROD_WIDTH      = WORD_WIDTH + VALUE_WIDTH;
   localparam int ACC_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [WORD_WIDTH-1:0] MIX1_MUL   = 32'h045d_9f3b;
   localparam logic [WORD_WIDTH-1:0] MIX2_MUL   = 32'h27d4_eb2d;
   localparam logic [WORD_WIDTH-1:0] MIX2_XOR   = 32'd61;
   localparam int                    SHIFT_HI   = 16;
   localparam int                    SHIFT_MIX2 = 15;

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 6'd32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROJECTION_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HASH_OFFSET      = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic                      load;
      logic                      issue_base;
      logic                      issue_proj;
      logic [PROJ_IDX_WIDTH-1:0] proj_idx;
      logic                      emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                   busy;
      logic [COUNT_WIDTH-1:0] active_count;
   } status_type;

endpackage

>>> hdl/srps_ctrl.sv
// controller: sequences base hash, projection issue, drain and signature transfer
module srps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_entry_present,
   input  logic               req_row_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output srps_pkg::cmd_type  cmd,
   input  srps_pkg::status_type status
);
   import srps_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_BASE      = 6'b000010,
      ST_BASE_WAIT = 6'b000100,
      ST_PROJ      = 6'b001000,
      ST_DRAIN     = 6'b010000,
      ST_EMIT      = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [PROJ_IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;
   logic                      idx_final;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx_final = ({1'b0, idx_ff} == COUNT_WIDTH'(status.active_count - 6'd1));

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      last_in        = last_ff;
      cmd.load       = 1'b0;
      cmd.issue_base = 1'b0;
      cmd.issue_proj = 1'b0;
      cmd.proj_idx   = idx_ff;
      cmd.emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_row_last;
               if (req_entry_present && status.active_count != '0) begin
                  state_in = ST_BASE;
               end else if (req_row_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_BASE: begin
            cmd.issue_base = 1'b1;
            state_in       = ST_BASE_WAIT;
         end
         ST_BASE_WAIT: begin
            if (!status.busy) begin
               idx_in   = '0;
               state_in = ST_PROJ;
            end
         end
         ST_PROJ: begin
            cmd.issue_proj = 1'b1;
            if (idx_final) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/srps_datapath.sv
// datapath: shared hash and multiply pipeline, accumulators, config and signature registers
module srps_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  srps_pkg::cmd_type                      cmd,
   output srps_pkg::status_type                   status,
   input  logic [srps_pkg::WORD_WIDTH-1:0]        req_column_index,
   input  logic signed [srps_pkg::VALUE_WIDTH-1:0] req_entry_value,
   input  logic                                   csr_write_enable,
   input  logic [srps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [srps_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output logic [srps_pkg::SIG_WIDTH-1:0]         rsp_signature
);
   import srps_pkg::*;

   logic [COUNT_WIDTH-1:0]       count_ff;
   logic [WORD_WIDTH-1:0]        offset_ff;
   logic [COUNT_WIDTH-1:0]       active_count;

   logic [WORD_WIDTH-1:0]        col_ff;
   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic [WORD_WIDTH-1:0]        base_ff;

   // mix2 of the column, free running off the held column
   logic [WORD_WIDTH-1:0]        m2_a, m2_b, m2_c;
   logic [WORD_WIDTH-1:0]        m2_pre_ff, m2_mul_ff, mix2_w;

   // pipeline stages
   logic [WORD_WIDTH-1:0]        key_w;
   logic [WORD_WIDTH-1:0]        s1_ff, s2_ff, s3_ff, s2_x, hash_w;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic                         v1_ff, v2_ff, v3_ff, v4_ff;
   logic                         b1_ff, b2_ff, b3_ff;
   logic [PROJ_IDX_WIDTH-1:0]    k1_ff, k2_ff, k3_ff, k4_ff;

   logic signed [ACC_WIDTH-1:0]  acc_ff [NUM_PROJECTIONS];
   logic signed [ACC_WIDTH-1:0]  acc_old, acc_add, acc_sum, acc_in;
   logic [SIG_WIDTH-1:0]         sig_w, sig_ff;

   assign active_count = (count_ff > COUNT_WIDTH'(NUM_PROJECTIONS)) ?
                         COUNT_WIDTH'(NUM_PROJECTIONS) : count_ff;

   assign status.active_count = active_count;
   assign status.busy         = v1_ff | v2_ff | v3_ff | v4_ff;
   assign rsp_signature       = sig_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         offset_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROJECTION_COUNT: count_ff  <= csr_write_data[COUNT_WIDTH-1:0];
            CSR_HASH_OFFSET:      offset_ff <= csr_write_data[WORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= req_column_index;
         val_ff <= req_entry_value;
      end
   end

   assign m2_a   = (col_ff ^ MIX2_XOR) ^ (col_ff >> SHIFT_HI);
   assign m2_b   = m2_a + (m2_a << 3);
   assign m2_c   = m2_b ^ (m2_b >> 4);
   assign mix2_w = m2_mul_ff ^ (m2_mul_ff >> SHIFT_MIX2);

   always_ff @(posedge clock) begin
      m2_pre_ff <= m2_c;
      m2_mul_ff <= m2_pre_ff * MIX2_MUL;
   end

   // stage 0: key select and first fold
   assign key_w = cmd.issue_base ? col_ff :
                  base_ff + WORD_WIDTH'(cmd.proj_idx) + offset_ff;
   assign s2_x   = s2_ff ^ (s2_ff >> SHIFT_HI);
   assign hash_w = s3_ff ^ (s3_ff >> SHIFT_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue_base | cmd.issue_proj;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff & !b3_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff   <= key_w ^ (key_w >> SHIFT_HI);
      b1_ff   <= cmd.issue_base;
      k1_ff   <= cmd.proj_idx;
      s2_ff   <= s1_ff * MIX1_MUL;
      b2_ff   <= b1_ff;
      k2_ff   <= k1_ff;
      s3_ff   <= s2_x * MIX1_MUL;
      b3_ff   <= b2_ff;
      k3_ff   <= k2_ff;
      prod_ff <= PROD_WIDTH'($signed(hash_w)) * PROD_WIDTH'(val_ff);
      k4_ff   <= k3_ff;
      if (v3_ff && b3_ff) begin
         base_ff <= hash_w + mix2_w;
      end
   end

   // saturating accumulate
   assign acc_old = acc_ff[k4_ff];
   assign acc_add = ACC_WIDTH'(prod_ff);
   assign acc_sum = acc_old + acc_add;

   always_comb begin
      if (acc_old[ACC_WIDTH-1] == acc_add[ACC_WIDTH-1] &&
          acc_sum[ACC_WIDTH-1] != acc_old[ACC_WIDTH-1]) begin
         acc_in = acc_old[ACC_WIDTH-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} :
                                         {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         acc_in = acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         for (int i = 0; i < NUM_PROJECTIONS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (v4_ff) begin
         acc_ff[k4_ff] <= acc_in;
      end
   end

   always_comb begin
      sig_w = '0;
      for (int i = 0; i < NUM_PROJECTIONS; i++) begin
         sig_w[i] = (COUNT_WIDTH'(i) < active_count) & ~acc_ff[i][ACC_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         sig_ff <= sig_w;
      end
   end

endmodule

>>> hdl/sparse_random_projection_signature.sv
// top level: sparse row signature from hashed random projections
// a nonzero entry runs a base hash, then one projection per cycle for n active projections
//   through the shared hash and multiply pipeline, then a drain before the next request
// an empty-row marker goes straight to the emit state; a row end goes there after its drain
// the result register frees the input side while a signature waits for transfer
// synchronous active-high reset resets control and config and clears all accumulators
module sparse_random_projection_signature (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [srps_pkg::WORD_WIDTH-1:0]         req_column_index,
   input  logic signed [srps_pkg::VALUE_WIDTH-1:0] req_entry_value,
   input  logic                                    req_entry_present,
   input  logic                                    req_row_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [srps_pkg::SIG_WIDTH-1:0]          rsp_signature,
   input  logic                                    csr_write_enable,
   input  logic [srps_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [srps_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import srps_pkg::*;

   cmd_type    cmd;
   status_type status;

   srps_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_entry_present (req_entry_present),
      .req_row_last      (req_row_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .cmd               (cmd),
      .status            (status)
   );

   srps_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_column_index (req_column_index),
      .req_entry_value  (req_entry_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_signature    (rsp_signature)
   );

endmodule

>>> hdl/srps_checker.sv
// port-level checks for the signature block, bound to the top level
module srps_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic [srps_pkg::WORD_WIDTH-1:0]         req_column_index,
   input logic signed [srps_pkg::VALUE_WIDTH-1:0] req_entry_value,
   input logic                                    req_entry_present,
   input logic                                    req_row_last,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic [srps_pkg::SIG_WIDTH-1:0]          rsp_signature,
   input logic                                    csr_write_enable,
   input logic [srps_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input logic [srps_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   // a waiting signature holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_signature))
      else $error("signature dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a marker without row end is dropped at once
   a_marker_skip: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_entry_present && !req_row_last |=> req_ready)
      else $error("ignored marker stalled the input");

   // row end always has work to do before the next transfer
   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_row_last |=> !req_ready)
      else $error("row end taken without producing a signature");

endmodule

bind sparse_random_projection_signature srps_checker u_checker (.*);
